// File: sv/rational_arith_unit_macros.svh
// Assertion helpers shared by the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rau_pkg.sv
package rau_pkg;

  localparam int MAG_W      = 64;
  localparam int CTZ_STAGES = 6;
  localparam int GCD_STEPS  = 2 * MAG_W;

  typedef logic [MAG_W-1:0] mag_t;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDIV = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // Information that rides alongside the magnitudes through the reduction.
  typedef struct packed {
    logic       neg;
    logic       fixed;
    logic [1:0] cmp;
    logic [1:0] status;
  } side_t;

endpackage

// File: sv/rau_gcd.sv
module rau_gcd (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            vld_i,
  input  rau_pkg::side_t  side_i,
  input  rau_pkg::mag_t   n_i,
  input  rau_pkg::mag_t   d_i,
  output logic            vld_o,
  output rau_pkg::side_t  side_o,
  output rau_pkg::mag_t   n_o,
  output rau_pkg::mag_t   d_o,
  output rau_pkg::mag_t   g_o
);

  localparam int NC = rau_pkg::CTZ_STAGES;
  localparam int NS = rau_pkg::GCD_STEPS;

  // Common powers of two are removed first, halving the shift each stage.
  logic           c_vld  [NC+1];
  rau_pkg::side_t c_side [NC+1];
  rau_pkg::mag_t  c_n    [NC+1];
  rau_pkg::mag_t  c_d    [NC+1];

  assign c_vld[0]  = vld_i;
  assign c_side[0] = side_i;
  assign c_n[0]    = n_i;
  assign c_d[0]    = d_i;

  for (genvar i = 0; i < NC; i++) begin : g_ctz
    localparam int SH = 32 >> i;
    localparam rau_pkg::mag_t MASK = (rau_pkg::mag_t'(1) << SH) - rau_pkg::mag_t'(1);
    logic even_w;
    assign even_w = ((c_n[i] | c_d[i]) & MASK) == '0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_vld[i+1] <= 1'b0;
      end else if (adv_i) begin
        c_vld[i+1] <= c_vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        c_side[i+1] <= c_side[i];
        c_n[i+1]    <= even_w ? (c_n[i] >> SH) : c_n[i];
        c_d[i+1]    <= even_w ? (c_d[i] >> SH) : c_d[i];
      end
    end
  end

  // Binary GCD, one subtract-and-halve step per stage; u is kept odd.
  logic           s_vld  [NS+1];
  rau_pkg::side_t s_side [NS+1];
  rau_pkg::mag_t  s_n    [NS+1];
  rau_pkg::mag_t  s_d    [NS+1];
  rau_pkg::mag_t  s_u    [NS+1];
  rau_pkg::mag_t  s_v    [NS+1];

  assign s_vld[0]  = c_vld[NC];
  assign s_side[0] = c_side[NC];
  assign s_n[0]    = c_n[NC];
  assign s_d[0]    = c_d[NC];
  assign s_u[0]    = c_n[NC][0] ? c_n[NC] : c_d[NC];
  assign s_v[0]    = c_n[NC][0] ? c_d[NC] : c_n[NC];

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic [rau_pkg::MAG_W:0] vmu_w;
    rau_pkg::mag_t           umv_w;
    rau_pkg::mag_t           u_d;
    rau_pkg::mag_t           v_d;

    assign vmu_w = {1'b0, s_v[i]} - {1'b0, s_u[i]};
    assign umv_w = s_u[i] - s_v[i];

    always_comb begin
      u_d = s_u[i];
      v_d = s_v[i];
      if (s_v[i] == '0) begin
        v_d = '0;
      end else if (!s_v[i][0]) begin
        v_d = s_v[i] >> 1;
      end else if (!vmu_w[rau_pkg::MAG_W]) begin
        v_d = vmu_w[rau_pkg::MAG_W-1:0] >> 1;
      end else begin
        u_d = s_v[i];
        v_d = umv_w >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_vld[i+1] <= 1'b0;
      end else if (adv_i) begin
        s_vld[i+1] <= s_vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        s_side[i+1] <= s_side[i];
        s_n[i+1]    <= s_n[i];
        s_d[i+1]    <= s_d[i];
        s_u[i+1]    <= u_d;
        s_v[i+1]    <= v_d;
      end
    end
  end

  assign vld_o  = s_vld[NS];
  assign side_o = s_side[NS];
  assign n_o    = s_n[NS];
  assign d_o    = s_d[NS];
  assign g_o    = s_u[NS];

endmodule

// File: sv/rau_div.sv
module rau_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            vld_i,
  input  rau_pkg::side_t  side_i,
  input  rau_pkg::mag_t   n_i,
  input  rau_pkg::mag_t   d_i,
  input  rau_pkg::mag_t   g_i,
  output logic            vld_o,
  output rau_pkg::side_t  side_o,
  output rau_pkg::mag_t   n_o,
  output rau_pkg::mag_t   d_o
);

  localparam int W = rau_pkg::MAG_W;

  // Two restoring dividers side by side, one quotient bit per stage.
  logic           p_vld  [W+1];
  rau_pkg::side_t p_side [W+1];
  rau_pkg::mag_t  p_g    [W+1];
  rau_pkg::mag_t  p_rn   [W+1];
  rau_pkg::mag_t  p_qn   [W+1];
  rau_pkg::mag_t  p_rd   [W+1];
  rau_pkg::mag_t  p_qd   [W+1];

  assign p_vld[0]  = vld_i;
  assign p_side[0] = side_i;
  assign p_g[0]    = g_i;
  assign p_rn[0]   = '0;
  assign p_qn[0]   = n_i;
  assign p_rd[0]   = '0;
  assign p_qd[0]   = d_i;

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0] tn_w, td_w, sn_w, sd_w;

    assign tn_w = {p_rn[i], p_qn[i][W-1]};
    assign td_w = {p_rd[i], p_qd[i][W-1]};
    assign sn_w = tn_w - {1'b0, p_g[i]};
    assign sd_w = td_w - {1'b0, p_g[i]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        p_vld[i+1] <= 1'b0;
      end else if (adv_i) begin
        p_vld[i+1] <= p_vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        p_side[i+1] <= p_side[i];
        p_g[i+1]    <= p_g[i];
        p_rn[i+1]   <= sn_w[W] ? tn_w[W-1:0] : sn_w[W-1:0];
        p_qn[i+1]   <= {p_qn[i][W-2:0], ~sn_w[W]};
        p_rd[i+1]   <= sd_w[W] ? td_w[W-1:0] : sd_w[W-1:0];
        p_qd[i+1]   <= {p_qd[i][W-2:0], ~sd_w[W]};
      end
    end
  end

  assign vld_o  = p_vld[W];
  assign side_o = p_side[W];
  assign n_o    = p_qn[W];
  assign d_o    = p_qd[W];

endmodule

// File: sv/rational_arith_unit.sv
// Rational arithmetic unit. Each transaction carries two fractions a_num/a_den and
// b_num/b_den and a command (add, subtract, multiply, divide, compare; unused
// codes act as compare). The exact cross products are formed at 64 bits, the
// result is reduced by the GCD of its magnitudes, and the sign is moved onto
// res_num so res_den is always positive. cmp_sign gives the sign of a - b on
// every command, but reads equal when a denominator is zero. A zero denominator
// or a divide by zero returns 0/1 with status 1; a reduced result outside WIDTH
// bits returns 0/1 with status 2. The unit is fully pipelined: it accepts one
// transaction per clock while the pipe is not held, and each result passes
// through 203 register stages (input register, multiply, add, select, six
// trailing-zero stages, 128 binary GCD steps, 64 divide steps and the output
// register). The binary GCD chain makes up most of those stages. When a result
// waits on out_stall_i the whole pipe holds, so in_stall_o follows.
module rational_arith_unit #(
  parameter int WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic signed [31:0] a_num_i,
  input  logic signed [31:0] a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic signed [31:0] b_den_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] res_num_o,
  output logic [30:0] res_den_o,
  output logic [1:0]  cmp_sign_o,
  output logic [1:0]  status_o
);

  localparam rau_pkg::mag_t LIM = (rau_pkg::mag_t'(1) << (WIDTH - 1)) - rau_pkg::mag_t'(1);

  logic adv;
  logic out_vld_q;

  // The pipe moves whenever the output register is free or being emptied.
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Stage 1: register operands as sign and magnitude.
  logic        s1_vld_q;
  logic [2:0]  s1_cmd_q;
  logic [31:0] an_m_q, ad_m_q, bn_m_q, bd_m_q;
  logic        an_s_q, ad_s_q, bn_s_q, bd_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q <= cmd_i;
      an_s_q   <= a_num_i[31];
      ad_s_q   <= a_den_i[31];
      bn_s_q   <= b_num_i[31];
      bd_s_q   <= b_den_i[31];
      an_m_q   <= a_num_i[31] ? (32'd0 - a_num_i) : a_num_i;
      ad_m_q   <= a_den_i[31] ? (32'd0 - a_den_i) : a_den_i;
      bn_m_q   <= b_num_i[31] ? (32'd0 - b_num_i) : b_num_i;
      bd_m_q   <= b_den_i[31] ? (32'd0 - b_den_i) : b_den_i;
    end
  end

  // Stage 2: the five cross products, one 32x32 multiplier each.
  logic          s2_vld_q;
  logic [2:0]    s2_cmd_q;
  logic          s2_zden_q, s2_bzero_q;
  rau_pkg::mag_t p_ab_q, p_ba_q, p_dd_q, p_nn_q, p_db_q;
  logic          g_ab_q, g_ba_q, g_dd_q, g_nn_q, g_db_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_zden_q  <= (ad_m_q == '0) || (bd_m_q == '0);
      s2_bzero_q <= bn_m_q == '0;
      p_ab_q     <= 64'(an_m_q) * 64'(bd_m_q);
      p_ba_q     <= 64'(bn_m_q) * 64'(ad_m_q);
      p_dd_q     <= 64'(ad_m_q) * 64'(bd_m_q);
      p_nn_q     <= 64'(an_m_q) * 64'(bn_m_q);
      p_db_q     <= 64'(ad_m_q) * 64'(bn_m_q);
      g_ab_q     <= an_s_q ^ bd_s_q;
      g_ba_q     <= bn_s_q ^ ad_s_q;
      g_dd_q     <= ad_s_q ^ bd_s_q;
      g_nn_q     <= an_s_q ^ bn_s_q;
      g_db_q     <= ad_s_q ^ bn_s_q;
    end
  end

  // Stage 3: sum and difference of the cross products in two's complement.
  logic [64:0] x_ab, x_ba;
  assign x_ab = g_ab_q ? (65'd0 - {1'b0, p_ab_q}) : {1'b0, p_ab_q};
  assign x_ba = g_ba_q ? (65'd0 - {1'b0, p_ba_q}) : {1'b0, p_ba_q};

  logic          s3_vld_q;
  logic [2:0]    s3_cmd_q;
  logic          s3_zden_q, s3_bzero_q;
  logic [64:0]   sum_q, diff_q;
  rau_pkg::mag_t s3_ab_q, s3_dd_q, s3_nn_q, s3_db_q;
  logic          s3_gab_q, s3_gdd_q, s3_gnn_q, s3_gdb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_cmd_q   <= s2_cmd_q;
      s3_zden_q  <= s2_zden_q;
      s3_bzero_q <= s2_bzero_q;
      sum_q      <= x_ab + x_ba;
      diff_q     <= x_ab - x_ba;
      s3_ab_q    <= p_ab_q;
      s3_dd_q    <= p_dd_q;
      s3_nn_q    <= p_nn_q;
      s3_db_q    <= p_db_q;
      s3_gab_q   <= g_ab_q;
      s3_gdd_q   <= g_dd_q;
      s3_gnn_q   <= g_nn_q;
      s3_gdb_q   <= g_db_q;
    end
  end

  // Stage 4: compare sign, operand selection and the special cases.
  logic [1:0]     cmp_w;
  logic [64:0]    nsel_w;
  rau_pkg::mag_t  n_mag_w, d_mag_w;
  logic           n_neg_w, d_neg_w;
  rau_pkg::side_t side_w;

  always_comb begin
    if (diff_q == '0) begin
      cmp_w = rau_pkg::CMP_EQ;
    end else if (diff_q[64] != s3_gdd_q) begin
      cmp_w = rau_pkg::CMP_LT;
    end else begin
      cmp_w = rau_pkg::CMP_GT;
    end

    nsel_w  = sum_q;
    d_mag_w = s3_dd_q;
    d_neg_w = s3_gdd_q;
    unique case (s3_cmd_q)
      rau_pkg::CMD_ADD: nsel_w = sum_q;
      rau_pkg::CMD_SUB: nsel_w = diff_q;
      rau_pkg::CMD_MUL: begin
        nsel_w = s3_gnn_q ? (65'd0 - {1'b0, s3_nn_q}) : {1'b0, s3_nn_q};
      end
      rau_pkg::CMD_DIV: begin
        nsel_w  = s3_gab_q ? (65'd0 - {1'b0, s3_ab_q}) : {1'b0, s3_ab_q};
        d_mag_w = s3_db_q;
        d_neg_w = s3_gdb_q;
      end
      default: nsel_w = '0;
    endcase
    n_neg_w = nsel_w[64];
    n_mag_w = nsel_w[64] ? (~nsel_w[63:0] + 64'd1) : nsel_w[63:0];

    side_w.neg    = n_neg_w ^ d_neg_w;
    side_w.fixed  = 1'b0;
    side_w.cmp    = cmp_w;
    side_w.status = rau_pkg::ST_OK;
    if (s3_zden_q) begin
      side_w.fixed  = 1'b1;
      side_w.cmp    = rau_pkg::CMP_EQ;
      side_w.status = rau_pkg::ST_ZDIV;
    end else if (s3_cmd_q == rau_pkg::CMD_DIV && s3_bzero_q) begin
      side_w.fixed  = 1'b1;
      side_w.status = rau_pkg::ST_ZDIV;
    end else if (s3_cmd_q >= rau_pkg::CMD_CMP || n_mag_w == '0) begin
      side_w.fixed  = 1'b1;
    end

    // Forced results still travel the pipe; feed them a harmless 1/1.
    if (side_w.fixed) begin
      n_mag_w = 64'd1;
      d_mag_w = 64'd1;
    end
  end

  logic           s4_vld_q;
  rau_pkg::side_t s4_side_q;
  rau_pkg::mag_t  s4_n_q, s4_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_side_q <= side_w;
      s4_n_q    <= n_mag_w;
      s4_d_q    <= d_mag_w;
    end
  end

  // GCD: strip common twos, then the odd part by binary steps.
  logic           gc_vld;
  rau_pkg::side_t gc_side;
  rau_pkg::mag_t  gc_n, gc_d, gc_g;

  rau_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s4_vld_q),
    .side_i (s4_side_q),
    .n_i    (s4_n_q),
    .d_i    (s4_d_q),
    .vld_o  (gc_vld),
    .side_o (gc_side),
    .n_o    (gc_n),
    .d_o    (gc_d),
    .g_o    (gc_g)
  );

  // Exact division of both terms by the odd part of the GCD.
  logic           dv_vld;
  rau_pkg::side_t dv_side;
  rau_pkg::mag_t  dv_n, dv_d;

  rau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (gc_vld),
    .side_i (gc_side),
    .n_i    (gc_n),
    .d_i    (gc_d),
    .g_i    (gc_g),
    .vld_o  (dv_vld),
    .side_o (dv_side),
    .n_o    (dv_n),
    .d_o    (dv_d)
  );

  // Output stage: range check against WIDTH and final formatting.
  logic          ovf_w;
  rau_pkg::mag_t nlim_w;
  logic [31:0]   num_w;

  assign nlim_w = dv_side.neg ? (LIM + 64'd1) : LIM;
  assign ovf_w  = (dv_n > nlim_w) || (dv_d > LIM);
  assign num_w  = dv_side.neg ? (32'd0 - dv_n[31:0]) : dv_n[31:0];

  logic [31:0] res_num_q;
  logic [30:0] res_den_q;
  logic [1:0]  cmp_q, status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmp_q <= dv_side.cmp;
      if (dv_side.fixed) begin
        res_num_q <= '0;
        res_den_q <= 31'd1;
        status_q  <= dv_side.status;
      end else if (ovf_w) begin
        res_num_q <= '0;
        res_den_q <= 31'd1;
        status_q  <= rau_pkg::ST_OVF;
      end else begin
        res_num_q <= num_w;
        res_den_q <= dv_d[30:0];
        status_q  <= rau_pkg::ST_OK;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign cmp_sign_o  = cmp_q;
  assign status_o    = status_q;

`include "rational_arith_unit_macros.svh"

  // Any error or overflow result must be the canonical 0/1.
  `RAU_ASSERT_NOW(a_err_canon, out_vld_q && status_q != rau_pkg::ST_OK, res_num_q == '0 && res_den_q == 31'd1, "error result is not 0/1")
  // A zero result is always returned as 0/1.
  `RAU_ASSERT_NOW(a_zero_canon, out_vld_q && res_num_q == '0, res_den_q == 31'd1, "zero result has a denominator other than 1")
  // The reduced denominator is never zero.
  `RAU_ASSERT_NOW(a_den_nz, out_vld_q, res_den_q != '0, "result denominator is zero")
  // A stalled output stage freezes the whole pipe, so the input is stalled too.
  `RAU_ASSERT_NOW(a_hold_in, out_vld_q && out_stall_i, in_stall_o, "input accepted while output stalled")

endmodule
